/* design/faa_pkg.sv */
// Shared types, constants and helpers for the first-fit block allocator.
package faa_pkg;

  localparam int BLOCK_BYTES     = 32;
  localparam int MAX_POOL_BLOCKS = 1024;

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_BLK_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int CNT_W      = $clog2(MAX_POOL_BLOCKS + 1);
  localparam int IDX_W      = (MAX_POOL_BLOCKS > 1) ? $clog2(MAX_POOL_BLOCKS) : 1;
  localparam int MAP_AW     = IDX_W + 1;
  localparam int MAP_DEPTH  = 2 * MAX_POOL_BLOCKS;
  localparam int NEED_W     = SIZE_W + 1 - BLOCK_SHIFT;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_BLOCKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_BASE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_BLOCKS   = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_DOUBLE  = 2'd3
  } faa_status_t;

  typedef enum logic [1:0] {
    MAP_FREE  = 2'd0,
    MAP_TAKEN = 2'd1,
    MAP_LAST  = 2'd2
  } map_code_t;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] size_bytes;
    logic              fast_pool;
    logic [ADDR_W-1:0] address;
  } faa_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    normal_base;
    logic [CFG_BLK_W-1:0] normal_blocks;
    logic [ADDR_W-1:0]    fast_base;
    logic [CFG_BLK_W-1:0] fast_blocks;
  } faa_cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address_res;
    faa_status_t       status;
  } faa_res_t;

  typedef struct packed {
    logic              we;
    logic [MAP_AW-1:0] waddr;
    map_code_t         wdata;
    logic [MAP_AW-1:0] raddr;
  } faa_map_req_t;

  function automatic logic [CNT_W-1:0] sat_count(input logic [CFG_BLK_W-1:0] v);
    if (int'(v) > MAX_POOL_BLOCKS) begin
      return CNT_W'(MAX_POOL_BLOCKS);
    end
    return CNT_W'(v);
  endfunction

endpackage

/* design/faa_map.sv */
// Block state map memory with a clearing sweep after reset.
module faa_map import faa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  faa_map_req_t req,
  output map_code_t    rdata,
  output logic         ready
);

  map_code_t         mem [MAP_DEPTH];
  logic              clr_active;
  logic [MAP_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + MAP_AW'(1);
      if (clr_addr == MAP_AW'(MAP_DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_addr] <= MAP_FREE;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

  assign ready = !clr_active;

endmodule

/* design/faa_engine.sv */
// Sequencer for first-fit scan, run marking and chunk release.
module faa_engine import faa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  faa_cmd_t     cmd,
  input  faa_cfg_t     cfg,
  output faa_map_req_t map_req,
  input  map_code_t    map_rdata,
  output logic         done,
  output faa_res_t     res
);

  typedef enum logic [3:0] {
    S_IDLE, S_NEED, S_FIT, S_MATCH_N, S_MATCH_F, S_SCAN, S_MARK, S_WALK, S_DONE
  } state_t;

  state_t            state;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;
  logic              pool;
  logic [NEED_W-1:0] need;
  logic [CNT_W-1:0]  issue_idx;
  logic              rd_pend;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  run_start;
  logic [CNT_W-1:0]  run_len;
  logic [IDX_W-1:0]  mark_idx;
  logic [IDX_W-1:0]  hit_idx;
  logic [ADDR_W-1:0] res_addr;
  faa_status_t       res_status;

  logic [CNT_W-1:0]  cnt_n, cnt_f, pool_cnt, match_cnt;
  logic [ADDR_W-1:0] pool_base, match_base;
  logic [ADDR_W:0]   diff;
  logic              in_range;
  logic [SIZE_W:0]   size_sum;
  logic [NEED_W-1:0] need_raw;
  logic              issue_go;
  logic              rd_last;
  logic              run_hit;
  logic [IDX_W-1:0]  start_now;

  assign cnt_n      = sat_count(cfg.normal_blocks);
  assign cnt_f      = sat_count(cfg.fast_blocks);
  assign pool_cnt   = pool ? cnt_f : cnt_n;
  assign pool_base  = pool ? cfg.fast_base : cfg.normal_base;
  assign match_cnt  = (state == S_MATCH_F) ? cnt_f : cnt_n;
  assign match_base = (state == S_MATCH_F) ? cfg.fast_base : cfg.normal_base;

  assign diff     = {1'b0, addr_r} - {1'b0, match_base};
  assign in_range = !diff[ADDR_W] &&
                    (diff[ADDR_W-1:0] < (ADDR_W'(match_cnt) << BLOCK_SHIFT));

  assign size_sum = {1'b0, size_r} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
  assign need_raw = size_sum[SIZE_W:BLOCK_SHIFT];

  assign issue_go  = issue_idx < pool_cnt;
  assign rd_last   = (CNT_W'(rd_idx) + CNT_W'(1)) == pool_cnt;
  assign run_hit   = (NEED_W'(run_len) + NEED_W'(1)) >= need;
  assign start_now = (run_len == '0) ? rd_idx : run_start;

  always_comb begin
    map_req.we    = 1'b0;
    map_req.waddr = {pool, mark_idx};
    map_req.wdata = MAP_TAKEN;
    map_req.raddr = {pool, issue_idx[IDX_W-1:0]};
    case (state)
      S_MARK: begin
        map_req.we    = 1'b1;
        map_req.wdata = (mark_idx == hit_idx) ? MAP_LAST : MAP_TAKEN;
      end
      S_WALK: begin
        if (rd_pend && map_rdata != MAP_FREE) begin
          map_req.we    = 1'b1;
          map_req.waddr = {pool, rd_idx};
          map_req.wdata = MAP_FREE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            size_r <= cmd.size_bytes;
            addr_r <= cmd.address;
            pool   <= cmd.fast_pool;
            state  <= (cmd.op == OP_FREE) ? S_MATCH_N : S_NEED;
          end
        end
        S_NEED: begin
          need  <= (need_raw == '0) ? NEED_W'(1) : need_raw;
          state <= S_FIT;
        end
        S_FIT: begin
          issue_idx <= '0;
          rd_pend   <= 1'b0;
          run_len   <= '0;
          if (need > NEED_W'(pool_cnt)) begin
            res_addr   <= '0;
            res_status <= ST_NOSPACE;
            state      <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_MATCH_N, S_MATCH_F: begin
          issue_idx <= CNT_W'(diff[BLOCK_SHIFT+IDX_W-1:BLOCK_SHIFT]);
          rd_pend   <= 1'b0;
          res_addr  <= '0;
          if (in_range) begin
            pool  <= (state == S_MATCH_F);
            state <= S_WALK;
          end else if (state == S_MATCH_N) begin
            state <= S_MATCH_F;
          end else begin
            res_status <= ST_OUTSIDE;
            state      <= S_DONE;
          end
        end
        S_SCAN: begin
          rd_pend <= issue_go;
          rd_idx  <= issue_idx[IDX_W-1:0];
          if (issue_go) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          if (rd_pend) begin
            if (map_rdata != MAP_FREE) begin
              run_len <= '0;
              if (rd_last) begin
                res_addr   <= '0;
                res_status <= ST_NOSPACE;
                state      <= S_DONE;
              end
            end else begin
              run_start <= start_now;
              if (run_hit) begin
                mark_idx <= start_now;
                hit_idx  <= rd_idx;
                state    <= S_MARK;
              end else begin
                run_len <= run_len + CNT_W'(1);
                if (rd_last) begin
                  res_addr   <= '0;
                  res_status <= ST_NOSPACE;
                  state      <= S_DONE;
                end
              end
            end
          end
        end
        S_MARK: begin
          if (mark_idx == hit_idx) begin
            res_addr   <= pool_base + (ADDR_W'(run_start) << BLOCK_SHIFT);
            res_status <= ST_OK;
            state      <= S_DONE;
          end else begin
            mark_idx <= mark_idx + IDX_W'(1);
          end
        end
        S_WALK: begin
          rd_pend <= issue_go;
          rd_idx  <= issue_idx[IDX_W-1:0];
          if (issue_go) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          if (rd_pend) begin
            if (map_rdata == MAP_FREE) begin
              res_status <= ST_DOUBLE;
              state      <= S_DONE;
            end else if (map_rdata == MAP_LAST || rd_last) begin
              res_status <= ST_OK;
              state      <= S_DONE;
            end
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done            = (state == S_DONE);
  assign res.address_res = res_addr;
  assign res.status      = res_status;

endmodule

/* design/first_fit_block_allocator_unit.sv */
// Top level: first-fit block allocator over a normal and a fast pool.
// Allocate: scans the map entries for a free run, then marks the blocks of the run,
// through the one-entry-per-cycle map port. Free: walks the map entries of the chunk.
// One item at a time; ready again after the result transfer. After reset all
// 2 * MAX_POOL_BLOCKS (2048) map entries are swept to free, during which input is
// stalled; configuration writes are taken.
module first_fit_block_allocator_unit import faa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [SIZE_W-1:0]    size_bytes,
  input  logic                 fast_pool,
  input  logic [ADDR_W-1:0]    address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    address_res,
  output logic [1:0]           status
);

  faa_cfg_t     cfg;
  faa_cmd_t     cmd;
  faa_res_t     eng_res;
  faa_map_req_t map_req;
  map_code_t    map_rdata;
  logic         map_ready;
  logic         eng_done;
  logic         busy;
  logic         in_xfer;
  logic [ADDR_W-1:0] out_addr;
  faa_status_t  out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NORMAL_BASE:   cfg.normal_base   <= cfg_data;
        REG_NORMAL_BLOCKS: cfg.normal_blocks <= cfg_data[CFG_BLK_W-1:0];
        REG_FAST_BASE:     cfg.fast_base     <= cfg_data;
        REG_FAST_BLOCKS:   cfg.fast_blocks   <= cfg_data[CFG_BLK_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = busy || !map_ready;
  assign in_xfer  = in_valid && !in_stall;

  assign cmd.op         = op;
  assign cmd.size_bytes = size_bytes;
  assign cmd.fast_pool  = fast_pool;
  assign cmd.address    = address;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy <= 1'b1;
      end
      if (eng_done) begin
        out_valid  <= 1'b1;
        out_addr   <= eng_res.address_res;
        out_status <= eng_res.status;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
        busy      <= 1'b0;
      end
    end
  end

  assign address_res = out_addr;
  assign status      = out_status;

  faa_map u_map (
    .clk   (clk),
    .rst   (rst),
    .req   (map_req),
    .rdata (map_rdata),
    .ready (map_ready)
  );

  faa_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (in_xfer),
    .cmd       (cmd),
    .cfg       (cfg),
    .map_req   (map_req),
    .map_rdata (map_rdata),
    .done      (eng_done),
    .res       (eng_res)
  );

  a_out_needs_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy) else $error("result pending without an item in flight");

  a_done_slot_free: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> busy && !out_valid) else $error("engine finished with no free slot");

  a_no_work_in_clear: assert property (@(posedge clk) disable iff (rst)
    !map_ready |-> !busy) else $error("item in flight during map clear");

endmodule

/* tb/tb_first_fit_block_allocator_unit.sv */
// Testbench for the first-fit block allocator: directed and random alloc/free traffic.
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_unit import faa_pkg::*;;

  localparam int QUIET_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 200;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 op = OP_ALLOC;
  logic [SIZE_W-1:0]    size_bytes = '0;
  logic                 fast_pool = 1'b0;
  logic [ADDR_W-1:0]    address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_W-1:0]    address_res;
  logic [1:0]           status;

  // Allocator shadow state
  logic [ADDR_W-1:0]    pool_base [2];
  logic [CFG_BLK_W-1:0] pool_blocks [2];
  map_code_t            blk_state [MAP_DEPTH];

  faa_cmd_t          pending [$];
  faa_res_t          expected_results [$];
  logic [ADDR_W-1:0] live_chunks [$];

  logic cmd_taken = 1'b0;
  int   send_gap_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  first_fit_block_allocator_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .size_bytes  (size_bytes),
    .fast_pool   (fast_pool),
    .address     (address),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .address_res (address_res),
    .status      (status)
  );

  always #5 clk = ~clk;

  function automatic int unsigned usable_blocks(int p);
    return (pool_blocks[p] > MAX_POOL_BLOCKS) ? MAX_POOL_BLOCKS : pool_blocks[p];
  endfunction

  function automatic bit in_pool_range(logic [ADDR_W-1:0] a, int p);
    logic [33:0] lim;
    lim = 34'(pool_base[p]) + 34'(usable_blocks(p)) * BLOCK_BYTES;
    return (a >= pool_base[p]) && (34'(a) < lim);
  endfunction

  function automatic faa_res_t allocate_chunk(logic [SIZE_W-1:0] bytes, int p);
    faa_res_t    r;
    logic [32:0] need;
    int unsigned cnt, off, run_len, run_at, i, j;
    r.address_res = '0;
    r.status = ST_NOSPACE;
    cnt = usable_blocks(p);
    off = p * MAX_POOL_BLOCKS;
    need = ({1'b0, bytes} + 33'(BLOCK_BYTES - 1)) / BLOCK_BYTES;
    if (need == 0) need = 1;
    if (need > cnt) return r;
    run_len = 0;
    run_at = 0;
    for (i = 0; i < cnt; i++) begin
      if (blk_state[off + i] != MAP_FREE) begin
        run_len = 0;
      end else begin
        if (run_len == 0) run_at = i;
        run_len++;
        if (run_len >= need) begin
          for (j = run_at; j < i; j++) blk_state[off + j] = MAP_TAKEN;
          blk_state[off + i] = MAP_LAST;
          r.address_res = pool_base[p] + 32'(run_at * BLOCK_BYTES);
          r.status = ST_OK;
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic faa_status_t release_chunk(logic [ADDR_W-1:0] a);
    int          p;
    int unsigned cnt, off;
    logic [31:0] idx;
    map_code_t   e;
    if (in_pool_range(a, 0)) p = 0;
    else if (in_pool_range(a, 1)) p = 1;
    else return ST_OUTSIDE;
    cnt = usable_blocks(p);
    off = p * MAX_POOL_BLOCKS;
    idx = (a - pool_base[p]) / BLOCK_BYTES;
    while (idx < cnt) begin
      e = blk_state[off + idx];
      if (e == MAP_FREE) return ST_DOUBLE;
      blk_state[off + idx] = MAP_FREE;
      if (e == MAP_LAST) return ST_OK;
      idx++;
    end
    return ST_OK;
  endfunction

  function automatic faa_res_t step_allocator(faa_cmd_t c);
    faa_res_t r;
    if (c.op == OP_ALLOC) begin
      r = allocate_chunk(c.size_bytes, c.fast_pool ? 1 : 0);
      if (r.status == ST_OK) live_chunks.push_back(r.address_res);
    end else begin
      r.address_res = '0;
      r.status = release_chunk(c.address);
    end
    return r;
  endfunction

  // Driver: one item per transfer, held until taken
  always @(negedge clk) begin : drive
    faa_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || cmd_taken) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        c = pending.pop_front();
        op <= c.op;
        size_bytes <= c.size_bytes;
        fast_pool <= c.fast_pool;
        address <= c.address;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: check results, then predict on input transfers
  always @(posedge clk) begin : watch
    faa_res_t want;
    bit       bad;
    cmd_taken <= !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        bad = 1'b1;
        want = '0;
      end else begin
        want = expected_results.pop_front();
        bad = (address_res !== want.address_res) || (status !== want.status);
      end
      if (bad) begin
        if (mismatches < 10) begin
          if (expected_results.size() == 0 && want == '0 && !(address_res === '0 && status === 2'd0))
            $display("unexpected result: addr %h status %0d", address_res, status);
          else
            $display("bad result: expected addr %h status %0d, got addr %h status %0d",
                     want.address_res, want.status, address_res, status);
        end
        mismatches++;
      end
    end
    if (!rst && in_valid && !in_stall)
      expected_results.push_back(step_allocator(faa_cmd_t'({op, size_bytes, fast_pool, address})));
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("first_fit_block_allocator_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_NORMAL_BASE:   pool_base[0] = val;
      REG_NORMAL_BLOCKS: pool_blocks[0] = val[CFG_BLK_W-1:0];
      REG_FAST_BASE:     pool_base[1] = val;
      REG_FAST_BLOCKS:   pool_blocks[1] = val[CFG_BLK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_slot();
    do begin
      @(posedge clk);
      #1;
    end while (pending.size() >= 2);
  endtask

  task automatic offer(input faa_cmd_t c);
    wait_slot();
    pending.push_back(c);
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    #1;
  endtask

  function automatic faa_cmd_t alloc_cmd(logic [SIZE_W-1:0] bytes, logic fast);
    faa_cmd_t c;
    c.op = OP_ALLOC;
    c.size_bytes = bytes;
    c.fast_pool = fast;
    c.address = $urandom;
    return c;
  endfunction

  function automatic faa_cmd_t free_cmd(logic [ADDR_W-1:0] a);
    faa_cmd_t c;
    c.op = OP_FREE;
    c.size_bytes = $urandom;
    c.fast_pool = $urandom_range(1);
    c.address = a;
    return c;
  endfunction

  function automatic faa_cmd_t next_item();
    faa_cmd_t c;
    int       sel, p, k;
    c = alloc_cmd($urandom, $urandom_range(1));
    p = c.fast_pool ? 1 : 0;
    sel = $urandom_range(99);
    if (sel < 45) begin
      k = $urandom_range(9);
      if (k < 6) c.size_bytes = $urandom_range(4 * BLOCK_BYTES);
      else if (k < 9) c.size_bytes = $urandom_range(usable_blocks(p) * BLOCK_BYTES + BLOCK_BYTES);
    end else if (sel < 82 && live_chunks.size() != 0) begin
      k = $urandom_range(live_chunks.size() - 1);
      c = free_cmd(live_chunks[k]);
      live_chunks.delete(k);
      if ($urandom_range(9) == 0) c.address += $urandom_range(3 * BLOCK_BYTES);
    end else if (sel < 92 && usable_blocks(p) != 0) begin
      c = free_cmd(pool_base[p] + $urandom_range(usable_blocks(p) * BLOCK_BYTES - 1));
    end else begin
      c = free_cmd($urandom);
    end
    return c;
  endfunction

  task automatic run_random(input int n);
    repeat (n) begin
      wait_slot();
      pending.push_back(next_item());
    end
  endtask

  task automatic release_live();
    wait_drained();
    while (live_chunks.size() != 0) offer(free_cmd(live_chunks.pop_front()));
    wait_drained();
  endtask

  task automatic reconfigure(input logic [31:0] nb, input logic [31:0] nn,
                             input logic [31:0] fb, input logic [31:0] fn);
    release_live();
    write_reg(REG_NORMAL_BASE, nb);
    write_reg(REG_NORMAL_BLOCKS, nn);
    write_reg(REG_FAST_BASE, fb);
    write_reg(REG_FAST_BLOCKS, fn);
  endtask

  initial begin
    logic [31:0] shared_base;
    foreach (blk_state[i]) blk_state[i] = MAP_FREE;
    pool_base[0] = '0;
    pool_base[1] = '0;
    pool_blocks[0] = '0;
    pool_blocks[1] = '0;
    send_gap_pct = 20;
    recv_stall_pct = 57;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // map sweep runs now; registers are taken meanwhile
    write_reg(REG_NORMAL_BASE, 32'h0000_1000);
    write_reg(REG_NORMAL_BLOCKS, 32'd8);
    write_reg(REG_FAST_BASE, 32'hFFFF_FFE0);
    write_reg(REG_FAST_BLOCKS, 32'hABCD_F7FF);

    offer(alloc_cmd(32'd0, 1'b0));
    offer(alloc_cmd(32'd1, 1'b0));
    offer(alloc_cmd(32'd64, 1'b0));
    offer(alloc_cmd(32'd33, 1'b0));
    offer(alloc_cmd(32'hFFFF_FFFF, 1'b0));
    offer(alloc_cmd(32'd97, 1'b0));
    offer(free_cmd(32'h0000_1000));
    offer(free_cmd(32'h0000_1000));
    offer(free_cmd(32'h0000_1041));
    offer(alloc_cmd(32'd96, 1'b0));
    offer(alloc_cmd(32'd64, 1'b0));
    offer(free_cmd(32'h0000_0FFF));
    offer(free_cmd(32'h0000_1100));
    offer(alloc_cmd(32'd32, 1'b1));
    offer(alloc_cmd(32'd64, 1'b1));
    offer(free_cmd(32'hFFFF_FFFF));
    offer(free_cmd(32'h0000_0000));
    offer(alloc_cmd(32'd32768, 1'b1));
    offer(free_cmd(32'h0000_1080));
    offer(alloc_cmd(32'd128, 1'b0));
    wait_drained();
    // chunk now runs past the shrunk pool end: no last mark is met
    write_reg(REG_NORMAL_BLOCKS, 32'd6);
    offer(free_cmd(32'h0000_1080));
    wait_drained();
    write_reg(REG_NORMAL_BLOCKS, 32'd0);
    write_reg(REG_FAST_BLOCKS, 32'd0);
    offer(alloc_cmd(32'd0, 1'b0));
    offer(alloc_cmd(32'd0, 1'b1));
    offer(free_cmd(32'hFFFF_FFE0));

    reconfigure($urandom & 32'hFFFF_FFE0, 32'd32, $urandom & 32'hFFFF_FFE0, 32'd20);
    run_random(75);
    wait_drained();
    run_random(75);

    send_gap_pct = 57;
    recv_stall_pct = 20;
    reconfigure($urandom, 32'd1024, 32'hFFFF_FC00, 32'd64);
    run_random(60);
    shared_base = $urandom & 32'hFFFF_FFE0;
    reconfigure(shared_base, 32'd1, shared_base, {$urandom_range(1023, 0), 11'd0} | 32'd40);
    run_random(30);
    hold_req++;
    run_random(120);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    reconfigure(32'h0000_0000, 32'hFFFF_F830, 32'h8000_0000, 32'd1030);
    run_random(120);
    reconfigure(32'hFFFF_FFE0, 32'd1, $urandom & 32'hFFFF_FFE0, 32'd24);
    run_random(75);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("first_fit_block_allocator_unit: match");
    end else begin
      $display("first_fit_block_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
